// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   // Store geometry.
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int RANK_BITS  = $clog2(ENTRIES);
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   // Capacity register and the width used to compare it against the fill count.
   localparam int CAP_BITS = 5;
   localparam int CMP_BITS = (CAP_BITS > COUNT_BITS) ? CAP_BITS : COUNT_BITS;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   // Statistics counters.
   localparam int STAT_BITS = 32;

   // Operation codes; the remaining code is a no-operation.
   localparam logic [1:0] CMD_PUT    = 2'd0;
   localparam logic [1:0] CMD_GET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // One request item.
   typedef struct packed {
      logic [1:0]            cmd;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value_in;
   } req_type;

   // One response item.
   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] value_out;
      logic                  evicted;
      logic [COUNT_BITS-1:0] entry_count;
      logic [STAT_BITS-1:0]  hit_count;
      logic [STAT_BITS-1:0]  miss_count;
      logic [STAT_BITS-1:0]  eviction_count;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// Each request (put, get or remove of one key) passes through the transfer,
// a lookup step that compares the key against all sixteen entries together
// with the search for the least recent entry, and an update step that updates
// the stores, the recency ranks and the counters and loads the response
// register. A new request is accepted only once the previous one has left the
// update step, which waits until the previous response has been transferred.
// A new request may be accepted and looked up while a response is waiting.
// The capacity register may be written at any time the block is idle.
module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lkvc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lkvc_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_wdata
);
   import lkvc_pkg::*;

   ctrl_cmd_type cmd;

   // Sequencing and handshakes.
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Stores, ranks and counters.
   lkvc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/lkvc_ctrl.sv =====
// Controller state machine for the LRU key-value cache: sequencing and handshakes.
module lkvc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lkvc_pkg::ctrl_cmd_type cmd
);
   import lkvc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs toward the datapath and the request channel.
   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The response is held until its transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/lkvc_datapath.sv =====
// Datapath for the LRU key-value cache: entry stores, recency ranks and counters.
module lkvc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::ctrl_cmd_type        cmd,
   input  lkvc_pkg::req_type             req_data,
   input  logic                          csr_we,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_wdata,
   output lkvc_pkg::rsp_type             rsp_data
);
   import lkvc_pkg::*;

   function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] v);
      sat_inc = (v == {STAT_BITS{1'b1}}) ? v : v + STAT_BITS'(1);
   endfunction

   // Architectural state.
   logic [KEY_BITS-1:0]   key_store_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_store_ff [ENTRIES];
   logic [ENTRIES-1:0]    entry_valid_ff;
   logic [ENTRIES-1:0]    entry_valid_in;
   logic [RANK_BITS-1:0]  rank_ff        [ENTRIES];
   logic [RANK_BITS-1:0]  rank_in        [ENTRIES];
   logic [COUNT_BITS-1:0] valid_total_ff;
   logic [COUNT_BITS-1:0] valid_total_in;
   logic [STAT_BITS-1:0]  hit_total_ff;
   logic [STAT_BITS-1:0]  hit_total_in;
   logic [STAT_BITS-1:0]  miss_total_ff;
   logic [STAT_BITS-1:0]  miss_total_in;
   logic [STAT_BITS-1:0]  evict_total_ff;
   logic [STAT_BITS-1:0]  evict_total_in;
   logic [CAP_BITS-1:0]   capacity_ff;

   // Captured request and lookup results.
   req_type               req_ff;
   logic [ENTRIES-1:0]    hit_vec_ff;
   logic [ENTRIES-1:0]    hit_vec_in;
   logic                  hit_ff;
   logic [RANK_BITS-1:0]  hit_rank_ff;
   logic [RANK_BITS-1:0]  hit_rank_in;
   logic [VALUE_BITS-1:0] hit_value_ff;
   logic [VALUE_BITS-1:0] hit_value_in;
   logic [ENTRIES-1:0]    oldest_vec_ff;
   logic [ENTRIES-1:0]    oldest_vec_in;
   logic                  full_ff;
   logic                  full_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   // Commit-stage decode.
   logic                  is_put;
   logic                  is_get;
   logic                  is_remove;
   logic                  do_touch;
   logic                  do_remove;
   logic                  do_insert;
   logic                  do_evict;
   logic [ENTRIES-1:0]    kill_vec;
   logic [ENTRIES-1:0]    free_mask;
   logic [ENTRIES-1:0]    new_vec;
   logic [CMP_BITS-1:0]   cap_wide;
   logic [CMP_BITS-1:0]   limit_wide;

   // Capacity register, written whenever the port strobes.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Request capture on transfer.
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Lookup: parallel key compare, oldest-entry search and the capacity check.
   always_comb begin
      hit_rank_in  = '0;
      hit_value_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec_in[i]    = entry_valid_ff[i] && (key_store_ff[i] == req_ff.key);
         oldest_vec_in[i] = entry_valid_ff[i] &&
                            ((COUNT_BITS'(rank_ff[i]) + COUNT_BITS'(1)) == valid_total_ff);
         hit_rank_in      = hit_rank_in  | (hit_vec_in[i] ? rank_ff[i] : '0);
         hit_value_in     = hit_value_in | (hit_vec_in[i] ? value_store_ff[i] : '0);
      end
      cap_wide   = CMP_BITS'(capacity_ff);
      limit_wide = (cap_wide > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_wide;
      full_in    = CMP_BITS'(valid_total_ff) >= limit_wide;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_vec_ff    <= hit_vec_in;
         hit_ff        <= |hit_vec_in;
         hit_rank_ff   <= hit_rank_in;
         hit_value_ff  <= hit_value_in;
         oldest_vec_ff <= oldest_vec_in;
         full_ff       <= full_in;
      end
   end

   // Commit decode: which of touch, remove, insert and evict this item performs.
   always_comb begin
      is_put    = req_ff.cmd == CMD_PUT;
      is_get    = req_ff.cmd == CMD_GET;
      is_remove = req_ff.cmd == CMD_REMOVE;
      do_touch  = hit_ff && (is_put || is_get);
      do_remove = hit_ff && is_remove;
      do_evict  = is_put && !hit_ff && full_ff;
      // With nothing stored and no room, the new entry is dropped at once.
      do_insert = is_put && !hit_ff && !(full_ff && (valid_total_ff == '0));
      kill_vec  = do_evict ? oldest_vec_ff : '0;
      free_mask = ~entry_valid_ff | kill_vec;
      // Lowest free slot, counting the one freed by the eviction.
      new_vec   = free_mask & (~free_mask + ENTRIES'(1));
   end

   // Next entry state.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         entry_valid_in[i] = (entry_valid_ff[i] && !kill_vec[i] &&
                              !(do_remove && hit_vec_ff[i])) ||
                             (do_insert && new_vec[i]);
         rank_in[i] = rank_ff[i];
         if (do_insert && new_vec[i]) begin
            rank_in[i] = '0;
         end else if (do_touch && hit_vec_ff[i]) begin
            rank_in[i] = '0;
         end else if (entry_valid_ff[i]) begin
            if (do_touch && (rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end else if (do_remove && (rank_ff[i] > hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] - RANK_BITS'(1);
            end else if (do_insert) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
      end
   end

   // Next totals.
   always_comb begin
      valid_total_in = valid_total_ff;
      if (do_remove) begin
         valid_total_in = valid_total_ff - COUNT_BITS'(1);
      end else if (do_insert && !do_evict) begin
         valid_total_in = valid_total_ff + COUNT_BITS'(1);
      end
      hit_total_in   = (is_get && hit_ff)  ? sat_inc(hit_total_ff)   : hit_total_ff;
      miss_total_in  = (is_get && !hit_ff) ? sat_inc(miss_total_ff)  : miss_total_ff;
      evict_total_in = do_evict            ? sat_inc(evict_total_ff) : evict_total_ff;
   end

   // Result of this item.
   always_comb begin
      rsp_in.found          = hit_ff && (is_put || is_get || is_remove);
      rsp_in.value_out      = (is_get && hit_ff) ? hit_value_ff : '0;
      rsp_in.evicted        = do_evict;
      rsp_in.entry_count    = valid_total_in;
      rsp_in.hit_count      = hit_total_in;
      rsp_in.miss_count     = miss_total_in;
      rsp_in.eviction_count = evict_total_in;
   end

   // Control state of the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         valid_total_ff <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else if (cmd.commit) begin
         entry_valid_ff <= entry_valid_in;
         valid_total_ff <= valid_total_in;
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= rank_in[i];
      end
   end

   // Key and value stores and the output register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < ENTRIES; i++) begin
            if (do_insert && new_vec[i]) begin
               key_store_ff[i]   <= req_ff.key;
               value_store_ff[i] <= req_ff.value_in;
            end else if (is_put && hit_vec_ff[i]) begin
               value_store_ff[i] <= req_ff.value_in;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

   // The fill count tracks the valid bits.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      valid_total_ff == COUNT_BITS'($countones(entry_valid_ff)))
      else $error("fill count differs from number of valid entries");

   // A key is held in at most one entry.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(hit_vec_ff))
      else $error("key matched more than one entry");

   // An insert always finds a free slot.
   a_insert_has_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_insert) |-> $onehot(new_vec))
      else $error("insert without a free slot");

   // The store never holds more entries than it has.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (valid_total_ff <= COUNT_BITS'(ENTRIES)))
      else $error("fill count beyond store size");

endmodule
